// File: rtl/core/loh_pkg.sv
package loh_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned CharW = 8;

  localparam int unsigned MixL = 10;
  localparam int unsigned MixR = 6;
  localparam int unsigned FinA = 3;
  localparam int unsigned FinB = 11;
  localparam int unsigned FinC = 15;

  localparam logic [CharW-1:0] UpperFirst = 8'h41;
  localparam logic [CharW-1:0] UpperLast  = 8'h5a;
  localparam logic [CharW-1:0] CaseOffset = 8'h20;

  typedef logic [HashW-1:0] hash_t;

  // key fully absorbed, waiting for the final mix
  typedef struct packed {
    logic  valid;
    hash_t pre;
  } pend_t;

  function automatic logic [CharW-1:0] fold_lower(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= UpperFirst && c <= UpperLast) begin
      r = c + CaseOffset;
    end
    return r;
  endfunction

  function automatic hash_t absorb(input hash_t h_in, input logic [CharW-1:0] c);
    hash_t h;
    h = h_in + {{(HashW-CharW){1'b0}}, c};
    h = h + (h << MixL);
    h = h ^ (h >> MixR);
    return h;
  endfunction

  function automatic hash_t finish(input hash_t h_in);
    hash_t h;
    h = h_in + (h_in << FinA);
    h = h ^ (h >> FinB);
    h = h + (h << FinC);
    return h;
  endfunction

endpackage

// File: rtl/core/lowercase_oaat_hash.sv
// channel   valid       stall       payload
// key       key_valid   key_stall   char_code[7:0], has_char, last
// hash      hash_valid  hash_stall  hash_value[31:0]
//
// one item per cycle while key_stall is low; a character is absorbed in the cycle
// it is taken; after its last item a key's sum waits in the final-mix register,
// then passes through the final mix into the output register
// rst is synchronous and clears the accumulator and both valid flags
// key_stall rises only when a finished key waits and the output register is held
module lowercase_oaat_hash (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [loh_pkg::CharW-1:0] char_code,
  input  logic                      has_char,
  input  logic                      last,
  input  logic                      key_valid,
  output logic                      key_stall,
  output logic [loh_pkg::HashW-1:0] hash_value,
  output logic                      hash_valid,
  input  logic                      hash_stall
);

  loh_pkg::pend_t pend;
  logic           take;

  loh_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_code),
    .has_char  (has_char),
    .last      (last),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .take      (take),
    .pend      (pend)
  );

  loh_final u_final (
    .clk        (clk),
    .rst        (rst),
    .pend       (pend),
    .take       (take),
    .hash_valid (hash_valid),
    .hash_stall (hash_stall),
    .hash_value (hash_value)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !hash_valid && !pend.valid)
    else $error("result valid right after reset");

  a_last_pends: assert property (@(posedge clk) disable iff (rst)
    key_valid && !key_stall && last |=> pend.valid)
    else $error("last item did not reach the final-mix register");

  a_pend_moves: assert property (@(posedge clk) disable iff (rst)
    pend.valid && !(hash_valid && hash_stall) |=> hash_valid)
    else $error("pending key not moved to the output register");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    pend.valid && hash_valid && hash_stall |-> key_stall)
    else $error("item taken while both stages are full");

endmodule

// File: rtl/core/loh_mix.sv
module loh_mix (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [loh_pkg::CharW-1:0] char_code,
  input  logic                      has_char,
  input  logic                      last,
  input  logic                      key_valid,
  output logic                      key_stall,
  input  logic                      take,
  output loh_pkg::pend_t            pend
);

  loh_pkg::hash_t accumulator;
  loh_pkg::hash_t accumulator_next;
  loh_pkg::hash_t mixed;
  logic           accept;

  assign key_stall = pend.valid && !take;
  assign accept    = key_valid && !key_stall;

  always_comb begin
    mixed = accumulator;
    if (has_char) begin
      mixed = loh_pkg::absorb(accumulator, loh_pkg::fold_lower(char_code));
    end
    accumulator_next = accumulator;
    if (accept) begin
      accumulator_next = last ? '0 : mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      pend.valid  <= 1'b0;
    end else begin
      accumulator <= accumulator_next;
      if (accept && last) begin
        pend.valid <= 1'b1;
        pend.pre   <= mixed;
      end else if (take) begin
        pend.valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/loh_final.sv
module loh_final (
  input  logic           clk,
  input  logic           rst,
  input  loh_pkg::pend_t pend,
  output logic           take,
  output logic           hash_valid,
  input  logic           hash_stall,
  output loh_pkg::hash_t hash_value
);

  // output register frees up when empty or when its item leaves
  assign take = !hash_valid || !hash_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (take) begin
      hash_valid <= pend.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pend.valid) begin
      hash_value <= loh_pkg::finish(pend.pre);
    end
  end

endmodule
